@@ hw/rtl/mouse_packet_decoder_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the mouse packet decoder
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MOUSE_PACKET_DECODER_MACROS_SVH
`define MOUSE_PACKET_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define MPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hw/rtl/mpd_pkg.sv @@
// ----------------------------------------------------------------------------
// mpd_pkg
// Types and constants shared by the mouse packet decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mpd_pkg;

    localparam int unsigned POS_W = 32;

    localparam logic [7:0] MASK_ALWAYS_ONE = 8'h08;
    localparam logic [7:0] MASK_OVERFLOW   = 8'hC0;
    localparam logic [7:0] MASK_X_SIGN     = 8'h10;
    localparam logic [7:0] MASK_Y_SIGN     = 8'h20;
    localparam logic [7:0] MASK_BUTTONS    = 8'h07;

    localparam logic [3:0] SKIP_COUNT_RST  = 4'd3;

    // one completed three-byte packet
    typedef struct packed {
        logic       valid;
        logic [7:0] header;
        logic [7:0] x_byte;
        logic [7:0] y_byte;
    } t_packet;

endpackage

`default_nettype wire

@@ hw/rtl/mpd_frame.sv @@
// ----------------------------------------------------------------------------
// mpd_frame
// Byte framer: header check, overflow skip and packet assembly.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mouse_packet_decoder_macros.svh"

module mpd_frame import mpd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic [3:0] i_skip_count,
    output t_packet    o_pkt
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_X,
        PH_Y
    } t_phase;

    t_phase     r_phase,    n_phase;
    logic       r_skipping, n_skipping;
    logic [3:0] r_skip_cnt, n_skip_cnt;
    logic [7:0] r_header,   n_header;
    logic [7:0] r_x_byte,   n_x_byte;
    logic [3:0] skip_inc;

    assign skip_inc = r_skip_cnt + 4'd1;

    always_comb begin
        n_phase    = r_phase;
        n_skipping = r_skipping;
        n_skip_cnt = r_skip_cnt;
        n_header   = r_header;
        n_x_byte   = r_x_byte;
        o_pkt.valid  = 1'b0;
        o_pkt.header = r_header;
        o_pkt.x_byte = r_x_byte;
        o_pkt.y_byte = i_byte;
        if (i_step) begin
            if (r_skipping) begin
                // end the skip once the count reaches the current setting
                if (skip_inc >= i_skip_count) begin
                    n_skipping = 1'b0;
                    n_skip_cnt = 4'd0;
                end else begin
                    n_skip_cnt = skip_inc;
                end
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        if ((i_byte & MASK_ALWAYS_ONE) == 8'd0) begin
                            n_phase = PH_HEADER;
                        end else if ((i_byte & MASK_OVERFLOW) != 8'd0) begin
                            n_skipping = (i_skip_count != 4'd0);
                            n_skip_cnt = 4'd0;
                        end else begin
                            n_header = i_byte;
                            n_phase  = PH_X;
                        end
                    end
                    PH_X: begin
                        n_x_byte = i_byte;
                        n_phase  = PH_Y;
                    end
                    PH_Y: begin
                        o_pkt.valid = 1'b1;
                        n_phase     = PH_HEADER;
                    end
                    default: begin
                        n_phase = PH_HEADER;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_skipping <= 1'b0;
            r_skip_cnt <= 4'd0;
        end else begin
            r_phase    <= n_phase;
            r_skipping <= n_skipping;
            r_skip_cnt <= n_skip_cnt;
        end
        r_header <= n_header;
        r_x_byte <= n_x_byte;
    end

    `MPD_ASSERT_IMP(a_skip_in_header, i_clk, i_rst_n, r_skipping, r_phase == PH_HEADER, "skip outside header phase")
    `MPD_ASSERT_IMP(a_pkt_on_y, i_clk, i_rst_n, o_pkt.valid, (r_phase == PH_Y) && i_step && !r_skipping, "packet emitted outside Y phase")

endmodule

`default_nettype wire

@@ hw/rtl/mouse_packet_decoder.sv @@
// ----------------------------------------------------------------------------
// mouse_packet_decoder
// Decodes a three-byte pointing-device byte stream into position updates.
// ----------------------------------------------------------------------------
// Input channel: one raw mouse byte per beat on i_data_byte, i_in_valid with
// o_in_stall. Output channel: one beat per completed packet with position,
// deltas and buttons, o_out_valid with i_out_stall.
// A byte accepted lands in the input register; the Y byte of a packet then
// produces its result beat in the result register, visible on the outputs.
// One byte per cycle while the receiver does not stall. A byte is framed
// and the position adders run combinationally between the two registers.
// Headers, X bytes, dropped and skipped bytes yield no beat.
// Reset (synchronous, i_rst_n low) returns the framer to the header phase,
// clears the skip logic and zeroes both positions; skip_count returns to 3.
// When the receiver stalls, the result register holds its beat; one more
// byte can sit in the input register, after which o_in_stall rises until
// the result is taken. skip_count is written through i_cfg_we/i_cfg_wdata;
// the user writes it only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mouse_packet_decoder_macros.svh"

module mouse_packet_decoder import mpd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [3:0]              i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [7:0]              i_data_byte,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [POS_W-1:0] o_position_x,
    output logic signed [POS_W-1:0] o_position_y,
    output logic signed [8:0]       o_delta_x,
    output logic signed [9:0]       o_delta_y_screen,
    output logic [2:0]              o_button_bits
);

    logic [3:0]       r_skip_count;
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    logic [POS_W-1:0] r_accum_x, n_accum_x;
    logic [POS_W-1:0] r_accum_y, n_accum_y;
    logic [8:0]       r_dx;
    logic [9:0]       r_ndy;
    logic [2:0]       r_buttons;

    logic             advance;
    logic             step;
    t_packet          pkt;
    logic [8:0]       dx;
    logic [8:0]       dy;
    logic [9:0]       dy_ext;
    logic [9:0]       ndy;

    // the result slot is free, or its beat leaves this cycle
    assign advance    = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    mpd_frame u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_byte       (r_in_byte),
        .i_skip_count (r_skip_count),
        .o_pkt        (pkt)
    );

    always_comb begin
        dx        = {((pkt.header & MASK_X_SIGN) != 8'd0), pkt.x_byte};
        dy        = {((pkt.header & MASK_Y_SIGN) != 8'd0), pkt.y_byte};
        dy_ext    = {dy[8], dy};
        ndy       = (~dy_ext) + 10'd1;
        n_accum_x = r_accum_x + {{(POS_W-9){dx[8]}}, dx};
        n_accum_y = r_accum_y + {{(POS_W-10){ndy[9]}}, ndy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_count <= SKIP_COUNT_RST;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_accum_x    <= '0;
            r_accum_y    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_skip_count <= i_cfg_wdata;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= pkt.valid;
            end
            if (pkt.valid) begin
                r_accum_x <= n_accum_x;
                r_accum_y <= n_accum_y;
            end
        end
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_data_byte;
        end
        if (pkt.valid) begin
            r_dx      <= dx;
            r_ndy     <= ndy;
            r_buttons <= 3'(pkt.header & MASK_BUTTONS);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_position_x     = r_accum_x;
    assign o_position_y     = r_accum_y;
    assign o_delta_x        = r_dx;
    assign o_delta_y_screen = r_ndy;
    assign o_button_bits    = r_buttons;

    `MPD_ASSERT_IMP(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall, r_out_valid && i_out_stall && r_in_valid, "input stalled with free result slot")
    `MPD_ASSERT_NXT(a_pkt_to_result, i_clk, i_rst_n, pkt.valid, r_out_valid, "completed packet lost")
    `MPD_ASSERT_NXT(a_accept_loads, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_in_valid, "accepted byte not captured")
    `MPD_ASSERT_IMP(a_pkt_needs_slot, i_clk, i_rst_n, pkt.valid, advance, "packet formed while result slot blocked")

endmodule

`default_nettype wire
